[src/ktg_pkg.sv]
package ktg_pkg;

   // fixed-point constants, Q.40 unless noted
   localparam logic signed [63:0] DT_Q40    = 64'sd10995116;
   localparam logic signed [63:0] QN_Q40    = 64'sd879609302;
   localparam logic signed [63:0] RN_Q40    = 64'sd19791209300;
   localparam logic signed [63:0] ONE_Q40   = 64'sd1099511627776;
   localparam logic signed [63:0] GAIN_SAT  = 64'sd1152921504606846976;
   localparam logic        [62:0] PROD_CAP  = 63'h4000000000000000;
   localparam logic signed [63:0] INT_ONE   = 64'sd262144;
   localparam logic signed [63:0] SLEEP_GAIN = 64'sd55000;
   localparam logic signed [63:0] SLEEP_BIAS = 64'sd21474836480;
   localparam logic        [22:0] LVL_MIN   = 23'd19661;
   localparam logic        [22:0] LVL_MAX   = 23'd6553600;
   localparam logic        [22:0] DB_LO     = 23'd62260;
   localparam logic        [22:0] DB_HI     = 23'd68812;
   localparam logic        [23:0] MEAS_NUM  = 24'd13107200;
   localparam logic        [27:0] BIN_OFFSET = 28'd1048576;
   localparam logic        [3:0]  BIN_LAST  = 4'd11;   // bin count minus one

   localparam logic signed [63:0] SAT40_HI = 64'sd549755813887;
   localparam logic signed [63:0] SAT40_LO = -64'sd549755813888;
   localparam logic signed [63:0] SAT48_HI = 64'sd140737488355327;
   localparam logic signed [63:0] SAT48_LO = -64'sd140737488355328;

   typedef enum logic [1:0] {
      SH_0,
      SH_2,
      SH_38,
      SH_40
   } sh_type;

   typedef enum logic [1:0] {
      CSR_KP,
      CSR_KI,
      CSR_MAX_SLEEP
   } csr_index_type;

   typedef enum logic [4:0] {
      STEP_MEAS,
      STEP_ZP,
      STEP_M2,
      STEP_M3,
      STEP_M4,
      STEP_K0,
      STEP_K1,
      STEP_LVL,
      STEP_RATE,
      STEP_C0,
      STEP_C1,
      STEP_C2,
      STEP_C3,
      STEP_INT,
      STEP_KP,
      STEP_KI,
      STEP_SLEEP
   } step_type;

   typedef struct packed {
      logic     capture;
      logic     start;
      step_type step;
      logic     load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic done;
   } dp_status_type;

   function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = (v > SAT40_HI) ? SAT40_HI : ((v < SAT40_LO) ? SAT40_LO : v);
      return r[39:0];
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = (v > SAT48_HI) ? SAT48_HI : ((v < SAT48_LO) ? SAT48_LO : v);
      return r[47:0];
   endfunction

endpackage

[src/ktg_if.sv]
interface ktg_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] pulse_count;
   modport source (output valid, output pulse_count, input ready);
   modport sink (input valid, input pulse_count, output ready);
endinterface

interface ktg_rsp_if;
   logic               valid;
   logic               ready;
   logic [19:0]        sleep_ns;
   logic [22:0]        level_out;
   logic signed [39:0] rate_out;
   logic signed [23:0] error_out;
   logic [31:0]        corrections;
   logic [3:0]         hist_bin;
   modport source (output valid, output sleep_ns, output level_out, output rate_out,
                   output error_out, output corrections, output hist_bin, input ready);
   modport sink (input valid, input sleep_ns, input level_out, input rate_out,
                 input error_out, input corrections, input hist_bin, output ready);
endinterface

[src/ktg_mul.sv]
module ktg_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   input  ktg_pkg::sh_type    sh,
   output logic               done,
   output logic signed [63:0] result
);
   import ktg_pkg::*;

   logic [63:0]  ua_ff, ub_ff;
   logic         neg_ff;
   sh_type       sh_ff;
   logic         busy_ff;
   logic [2:0]   cnt_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   pos_ff;
   logic         pp_vld_ff;
   logic [127:0] acc_ff;
   logic         done_ff;
   logic signed [63:0] result_ff;

   logic [31:0]  a_half, b_half;
   logic [63:0]  pp_in;
   logic [127:0] pp_wide;
   logic [127:0] mag_sh;
   logic [62:0]  mag_cap;

   assign a_half = cnt_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
   assign b_half = cnt_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
   assign pp_in  = a_half * b_half;

   always_comb begin
      case (pos_ff)
         2'd0:    pp_wide = {64'd0, pp_ff};
         2'd3:    pp_wide = {pp_ff, 64'd0};
         default: pp_wide = {32'd0, pp_ff, 32'd0};
      endcase
   end

   always_comb begin
      case (sh_ff)
         SH_0:    mag_sh = acc_ff;
         SH_2:    mag_sh = acc_ff >> 2;
         SH_38:   mag_sh = acc_ff >> 38;
         SH_40:   mag_sh = acc_ff >> 40;
         default: mag_sh = acc_ff;
      endcase
      mag_cap = (mag_sh > {65'd0, PROD_CAP}) ? PROD_CAP : mag_sh[62:0];
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (start) begin
         ua_ff     <= a[63] ? 64'(-a) : 64'(a);
         ub_ff     <= b[63] ? 64'(-b) : 64'(b);
         neg_ff    <= a[63] ^ b[63];
         sh_ff     <= sh;
         busy_ff   <= 1'b1;
         cnt_ff    <= 3'd0;
         acc_ff    <= 128'd0;
         pp_vld_ff <= 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff < 3'd4) begin
            pp_ff     <= pp_in;
            pos_ff    <= cnt_ff[1:0];
            pp_vld_ff <= 1'b1;
            cnt_ff    <= cnt_ff + 3'd1;
         end else if (cnt_ff == 3'd4) begin
            pp_vld_ff <= 1'b0;
            cnt_ff    <= 3'd5;
         end else begin
            result_ff <= neg_ff ? -$signed({1'b0, mag_cap}) : $signed({1'b0, mag_cap});
            done_ff   <= 1'b1;
            busy_ff   <= 1'b0;
         end
         if (pp_vld_ff) begin
            acc_ff <= acc_ff + pp_wide;
         end
      end
      if (reset) begin
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= 3'd0;
         pp_vld_ff <= 1'b0;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

[src/ktg_div.sv]
module ktg_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [49:0] rem_init,
   input  logic [59:0] dividend,
   input  logic [48:0] divisor,
   input  logic [5:0]  count,
   output logic        done,
   output logic [59:0] quotient
);
   logic [49:0] rem_ff;
   logic [59:0] bits_ff;
   logic [59:0] q_ff;
   logic [48:0] div_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [49:0] trial;
   logic        ge;

   // one quotient bit per cycle, restoring
   assign trial = {rem_ff[48:0], bits_ff[59]};
   assign ge    = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (start) begin
         rem_ff  <= rem_init;
         bits_ff <= dividend;
         q_ff    <= 60'd0;
         div_ff  <= divisor;
         cnt_ff  <= count;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         rem_ff  <= ge ? trial - {1'b0, div_ff} : trial;
         bits_ff <= {bits_ff[58:0], 1'b0};
         q_ff    <= {q_ff[58:0], ge};
         cnt_ff  <= cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

[src/ktg_dp.sv]
module ktg_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  ktg_pkg::ctrl_cmd_type  cmd,
   output ktg_pkg::dp_status_type status,
   input  logic [63:0]            pulse_count,
   input  logic signed [23:0]     kp,
   input  logic signed [23:0]     ki,
   input  logic [19:0]            max_sleep,
   output logic [19:0]            sleep_ns,
   output logic [22:0]            level_out,
   output logic signed [39:0]     rate_out,
   output logic signed [23:0]     error_out,
   output logic [31:0]            corrections,
   output logic [3:0]             hist_bin
);
   import ktg_pkg::*;

   // filter and controller state
   logic [63:0]        prev_ff;
   logic [63:0]        d_ff;
   logic [22:0]        meas_ff;
   logic signed [47:0] cov0_ff, cov1_ff, cov2_ff, cov3_ff;
   logic signed [39:0] lvl_ff, rate_ff;
   logic signed [19:0] integ_ff;
   logic [31:0]        corr_ff;

   // per-word temporaries
   logic signed [39:0] zp_ff;
   logic signed [47:0] m2_ff, m3_ff;
   logic signed [47:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [61:0] k0_ff, k1_ff;
   logic               kneg_ff;
   logic signed [47:0] kpe_ff;
   logic signed [49:0] drive_ff;
   logic [19:0]        sleep_ff;
   step_type           cur_ff;
   logic               done_ff;

   // result word
   logic [19:0]        out_sleep_ff;
   logic [22:0]        out_level_ff;
   logic signed [39:0] out_rate_ff;
   logic signed [23:0] out_err_ff;
   logic [31:0]        out_corr_ff;
   logic [3:0]         out_bin_ff;

   logic signed [63:0] mul_a, mul_b, mul_res;
   sh_type             mul_sh;
   logic               mul_start, mul_done;
   logic [49:0]        div_rem;
   logic [59:0]        div_num, div_q;
   logic [48:0]        div_den;
   logic [5:0]         div_cnt;
   logic               div_start, div_done, div_step, imm;

   logic signed [63:0] y, one_k0, s_val, k_num;
   logic [47:0]        k_mag;
   logic [22:0]        z;
   logic signed [23:0] err;
   logic [27:0]        z20;
   logic [11:0]        bin_raw;
   logic [3:0]         bin;

   assign y      = $signed({41'd0, meas_ff}) - 64'(zp_ff);
   assign one_k0 = ONE_Q40 - 64'(k0_ff);
   assign s_val  = 64'(p00_ff) + RN_Q40;
   assign k_num  = (cmd.step == STEP_K1) ? 64'(p10_ff) : 64'(p00_ff);
   assign k_mag  = k_num[63] ? 48'(-k_num) : k_num[47:0];

   // clamped level, error and histogram bin
   always_comb begin
      if (lvl_ff > $signed({17'd0, LVL_MAX})) begin
         z = LVL_MAX;
      end else if (lvl_ff < $signed({17'd0, LVL_MIN})) begin
         z = LVL_MIN;
      end else begin
         z = lvl_ff[22:0];
      end
      err     = 24'sd65536 - $signed({1'b0, z});
      z20     = {z, 4'd0} + {2'd0, z, 2'd0};
      bin_raw = (z20 < BIN_OFFSET) ? 12'd0 : 12'((z20 - BIN_OFFSET) >> 16);
      bin     = (bin_raw > {8'd0, BIN_LAST}) ? BIN_LAST : bin_raw[3:0];
   end

   // operand select
   always_comb begin
      mul_a  = 64'sd0;
      mul_b  = 64'sd0;
      mul_sh = SH_40;
      case (cmd.step)
         STEP_ZP:    begin mul_a = DT_Q40; mul_b = 64'(rate_ff); end
         STEP_M2:    begin mul_a = DT_Q40; mul_b = 64'(cov1_ff); end
         STEP_M3:    begin mul_a = DT_Q40; mul_b = 64'(cov3_ff); end
         STEP_M4:    begin mul_a = DT_Q40; mul_b = 64'(m3_ff); end
         STEP_LVL:   begin mul_a = 64'(k0_ff); mul_b = y; end
         STEP_RATE:  begin mul_a = 64'(k1_ff); mul_b = y; end
         STEP_C0:    begin mul_a = one_k0; mul_b = 64'(p00_ff); end
         STEP_C1:    begin mul_a = one_k0; mul_b = 64'(p01_ff); end
         STEP_C2:    begin mul_a = 64'(k1_ff); mul_b = 64'(p00_ff); end
         STEP_C3:    begin mul_a = 64'(k1_ff); mul_b = 64'(p01_ff); end
         STEP_INT:   begin mul_a = 64'(err); mul_b = DT_Q40; mul_sh = SH_38; end
         STEP_KP:    begin mul_a = 64'(kp); mul_b = 64'(err); mul_sh = SH_0; end
         STEP_KI:    begin mul_a = 64'(ki); mul_b = 64'(integ_ff); mul_sh = SH_2; end
         STEP_SLEEP: begin mul_a = SLEEP_GAIN; mul_b = 64'(drive_ff); mul_sh = SH_0; end
         default:    begin mul_sh = SH_40; end
      endcase
   end

   // divider setup, with the cases that need no division
   always_comb begin
      div_step = 1'b0;
      imm      = 1'b0;
      div_rem  = 50'd0;
      div_num  = 60'd0;
      div_den  = 49'd0;
      div_cnt  = 6'd0;
      case (cmd.step)
         STEP_MEAS: begin
            div_step = 1'b1;
            imm      = d_ff[63:32] != 32'd0;
            div_num  = {MEAS_NUM, 36'd0};
            div_den  = 49'({d_ff[31:0], 3'd0}) + 49'({d_ff[31:0], 1'b0}) + 49'd1;
            div_cnt  = 6'd24;
         end
         STEP_K0, STEP_K1: begin
            div_step = 1'b1;
            imm      = (s_val <= 64'sd0) ||
                       ({21'd0, k_mag} >= {s_val[48:0], 20'd0});
            div_rem  = 50'(k_mag[47:20]);
            div_num  = {k_mag[19:0], 40'd0};
            div_den  = s_val[48:0];
            div_cnt  = 6'd60;
         end
         default: begin
            div_step = 1'b0;
         end
      endcase
   end

   assign mul_start = cmd.start && !div_step;
   assign div_start = cmd.start && div_step && !imm;

   ktg_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .sh     (mul_sh),
      .done   (mul_done),
      .result (mul_res)
   );

   ktg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem),
      .dividend (div_num),
      .divisor  (div_den),
      .count    (div_cnt),
      .done     (div_done),
      .quotient (div_q)
   );

   logic signed [63:0] sum_int, v_sleep, drive_new;
   logic [31:0]        sleep_raw;
   logic [19:0]        sleep_new;
   logic signed [61:0] k_div;

   always_comb begin
      sum_int   = 64'(integ_ff) + mul_res;
      drive_new = -(64'(kpe_ff) + mul_res);
      v_sleep   = SLEEP_BIAS + mul_res;
      sleep_raw = (v_sleep <= 64'sd0) ? 32'd0 : v_sleep[63:32];
      sleep_new = (sleep_raw > {12'd0, max_sleep}) ? max_sleep : sleep_raw[19:0];
      k_div     = kneg_ff ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
   end

   always_ff @(posedge clock) begin
      done_ff <= (cmd.start && div_step && imm) || mul_done || div_done;

      if (cmd.capture) begin
         d_ff    <= pulse_count - prev_ff;
         prev_ff <= pulse_count;
      end

      if (cmd.start) begin
         cur_ff  <= cmd.step;
         kneg_ff <= k_num[63];
         if (div_step && imm) begin
            case (cmd.step)
               STEP_MEAS: meas_ff <= LVL_MIN;
               STEP_K0:   k0_ff <= (s_val <= 64'sd0) ? 62'sd0 :
                                   (k_num[63] ? 62'(-GAIN_SAT) : 62'(GAIN_SAT));
               STEP_K1:   k1_ff <= (s_val <= 64'sd0) ? 62'sd0 :
                                   (k_num[63] ? 62'(-GAIN_SAT) : 62'(GAIN_SAT));
               default:   meas_ff <= meas_ff;
            endcase
         end
      end

      if (div_done) begin
         case (cur_ff)
            STEP_MEAS: begin
               if (div_q[23:0] > {1'b0, LVL_MAX}) begin
                  meas_ff <= LVL_MAX;
               end else if (div_q[23:0] < {1'b0, LVL_MIN}) begin
                  meas_ff <= LVL_MIN;
               end else begin
                  meas_ff <= div_q[22:0];
               end
            end
            STEP_K0: k0_ff <= k_div;
            STEP_K1: k1_ff <= k_div;
            default: k0_ff <= k0_ff;
         endcase
      end

      if (mul_done) begin
         case (cur_ff)
            STEP_ZP: zp_ff <= sat40(64'(lvl_ff) + mul_res);
            STEP_M2: m2_ff <= mul_res[47:0];
            STEP_M3: m3_ff <= mul_res[47:0];
            STEP_M4: begin
               p00_ff <= sat48(64'(cov0_ff) + (64'(m2_ff) <<< 1) + mul_res + QN_Q40);
               p01_ff <= sat48(64'(cov1_ff) + 64'(m3_ff));
               p10_ff <= sat48(64'(cov2_ff) + 64'(m3_ff));
               p11_ff <= sat48(64'(cov3_ff) + QN_Q40);
            end
            STEP_LVL:  lvl_ff <= sat40(64'(zp_ff) + mul_res);
            STEP_RATE: rate_ff <= sat40(64'(rate_ff) + mul_res);
            STEP_C0:   cov0_ff <= sat48(mul_res);
            STEP_C1:   cov1_ff <= sat48(mul_res);
            STEP_C2:   cov2_ff <= sat48(64'(p10_ff) - mul_res);
            STEP_C3:   cov3_ff <= sat48(64'(p11_ff) - mul_res);
            STEP_INT: begin
               if (sum_int > INT_ONE) begin
                  integ_ff <= 20'(INT_ONE);
               end else if (sum_int < -INT_ONE) begin
                  integ_ff <= 20'(-INT_ONE);
               end else begin
                  integ_ff <= sum_int[19:0];
               end
            end
            STEP_KP: kpe_ff <= mul_res[47:0];
            STEP_KI: begin
               drive_ff <= (z >= DB_LO && z <= DB_HI) ? 50'sd0 : drive_new[49:0];
            end
            STEP_SLEEP: begin
               sleep_ff <= sleep_new;
               if (sleep_new > 20'd5) begin
                  corr_ff <= corr_ff + 32'd1;
               end
            end
            default: zp_ff <= zp_ff;
         endcase
      end

      if (cmd.load_out) begin
         out_sleep_ff <= sleep_ff;
         out_level_ff <= z;
         out_rate_ff  <= rate_ff;
         out_err_ff   <= err;
         out_corr_ff  <= corr_ff;
         out_bin_ff   <= bin;
      end

      if (reset) begin
         done_ff  <= 1'b0;
         prev_ff  <= 64'd0;
         cov0_ff  <= 48'(ONE_Q40);
         cov1_ff  <= 48'sd0;
         cov2_ff  <= 48'sd0;
         cov3_ff  <= 48'(ONE_Q40);
         lvl_ff   <= 40'sd65536;
         rate_ff  <= 40'sd0;
         integ_ff <= 20'sd0;
         corr_ff  <= 32'd0;
      end
   end

   assign status.done  = done_ff;
   assign sleep_ns     = out_sleep_ff;
   assign level_out    = out_level_ff;
   assign rate_out     = out_rate_ff;
   assign error_out    = out_err_ff;
   assign corrections  = out_corr_ff;
   assign hist_bin     = out_bin_ff;

endmodule

[src/ktg_ctrl.sv]
module ktg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ktg_pkg::ctrl_cmd_type  cmd,
   input  ktg_pkg::dp_status_type status
);
   import ktg_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_FINISH
   } state_type;

   state_type state_ff;
   step_type  step_ff;
   logic      start_ff;
   logic      rsp_valid_ff;
   logic      accept, out_free, load_out;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_out  = (state_ff == ST_FINISH) && out_free;

   always_ff @(posedge clock) begin
      start_ff <= 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               step_ff  <= STEP_MEAS;
               start_ff <= 1'b1;
               state_ff <= ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (status.done) begin
               if (step_ff == STEP_SLEEP) begin
                  state_ff <= ST_FINISH;
               end else begin
                  step_ff  <= step_type'(step_ff + 5'd1);
                  start_ff <= 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
         end
         default: state_ff <= ST_IDLE;
      endcase
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_MEAS;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign cmd.capture  = accept;
   assign cmd.start    = start_ff;
   assign cmd.step     = step_ff;
   assign cmd.load_out = load_out;

   // datapath only finishes a step that was issued and is being waited on
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.done |-> state_ff == ST_WAIT)
      else $error("step completion outside of wait");

   // a step start is a single-cycle pulse
   a_start_pulse: assert property (@(posedge clock) disable iff (reset)
      start_ff |=> !start_ff)
      else $error("step start held for more than one cycle");

   // a result load always presents the word on the next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result load did not raise valid");

   // no new word is taken while a step is in flight
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT) |-> !req_ready)
      else $error("input ready during step sequence");

endmodule

[src/kalman_pi_throttle_governor.sv]
// Throttle governor: each input word carries the cumulative work-pulse counter; the block
// forms the pulse delta, turns it into a measured level, runs a two-state Kalman tracker
// (level and rate) and a PI controller with a deadband around level 1.0, and returns one
// result word with the sleep command, filtered level, rate, error, the running count of
// corrections and a histogram bin. Words are handled one at a time, each as a sequence of
// steps on the bit-serial divider (24 steps for the measured level, 60 for each of the two
// Kalman gains, each skipped when the delta is too large to measure, when the innovation
// variance is not positive or when a gain saturates) and 14 passes through the shared
// multiplier, which builds each 64x64 product from four 32x32 partial products. A finished
// word is loaded into the output register only once that register is free, so a consumer that
// stalls holds off the next input word. Gains and the sleep ceiling are to be written over
// the csr port (byte addresses 0, 4 and 8) only while the block is idle; the block itself
// does not enforce this.
module kalman_pi_throttle_governor (
   input  logic        clock,
   input  logic        reset,
   ktg_req_if.sink     req_chan,
   ktg_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ktg_pkg::*;

   // configuration registers
   logic signed [23:0] kp_ff;
   logic signed [23:0] ki_ff;
   logic [19:0]        max_sleep_ff;
   csr_index_type      csr_idx;
   logic               csr_write;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register write, taken at the access phase
   always_ff @(posedge clock) begin
      if (csr_write) begin
         unique case (csr_idx)
            CSR_KP:        kp_ff        <= csr_pwdata[23:0];
            CSR_KI:        ki_ff        <= csr_pwdata[23:0];
            CSR_MAX_SLEEP: max_sleep_ff <= csr_pwdata[19:0];
            default:       kp_ff        <= kp_ff;
         endcase
      end
      if (reset) begin
         kp_ff        <= 24'sd131072;
         ki_ff        <= 24'sd16384;
         max_sleep_ff <= 20'd200000;
      end
   end

   // readback
   always_comb begin
      unique case (csr_idx)
         CSR_KP:        csr_prdata = {8'd0, kp_ff};
         CSR_KI:        csr_prdata = {8'd0, ki_ff};
         CSR_MAX_SLEEP: csr_prdata = {12'd0, max_sleep_ff};
         default:       csr_prdata = 32'd0;
      endcase
   end

   // sequencer
   ktg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // filter, controller arithmetic and the result register
   ktg_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .pulse_count (req_chan.pulse_count),
      .kp          (kp_ff),
      .ki          (ki_ff),
      .max_sleep   (max_sleep_ff),
      .sleep_ns    (rsp_chan.sleep_ns),
      .level_out   (rsp_chan.level_out),
      .rate_out    (rsp_chan.rate_out),
      .error_out   (rsp_chan.error_out),
      .corrections (rsp_chan.corrections),
      .hist_bin    (rsp_chan.hist_bin)
   );

endmodule
